// File: rtl/core/smf_pkg.sv
package smf_pkg;

  // counter widths
  localparam int DEPTH_BITS = 16;
  localparam int LEN_BITS   = 24;

  // character codes
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // scanner modes
  typedef enum logic [2:0] {
    MODE_START  = 3'd0,
    MODE_ERROR  = 3'd1,
    MODE_NORMAL = 3'd2,
    MODE_QUOTED = 3'd3,
    MODE_BSLASH = 3'd4,
    MODE_HASH   = 3'd5,
    MODE_HASHED = 3'd6,
    MODE_DONE   = 3'd7
  } mode_t;

  // per-byte status codes
  typedef enum logic [1:0] {
    ST_CONTINUE = 2'd0,
    ST_COMPLETE = 2'd1,
    ST_BAD_START = 2'd2,
    ST_BAD_HASH = 2'd3
  } status_t;

  // contents of the input register
  typedef struct packed {
    logic       vld;
    logic [7:0] data;
  } stage_t;

endpackage

// File: rtl/core/smf_ifs.sv
interface smf_in_if;
  import smf_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
  modport mon (input valid, input data_byte, input ready);
endinterface

interface smf_out_if;
  import smf_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] echo_byte;
  logic       keep_byte;
  logic [1:0] frame_status;

  modport source (output valid, output echo_byte, output keep_byte, output frame_status,
                  input ready);
  modport sink (input valid, input echo_byte, input keep_byte, input frame_status,
                output ready);
  modport mon (input valid, input echo_byte, input keep_byte, input frame_status,
               input ready);
endinterface

// File: rtl/core/smf_in_reg.sv
module smf_in_reg
  import smf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  smf_in_if.sink      in_ch,
  input  logic        take,
  output stage_t      stage
);

  logic       vld_r;
  logic [7:0] data_r;

  // free when empty or when the held request moves on this cycle
  assign in_ch.ready = !vld_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      vld_r <= 1'b1;
    end else if (take) begin
      vld_r <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      data_r <= in_ch.data_byte;
    end
  end

  assign stage.vld  = vld_r;
  assign stage.data = data_r;

endmodule

// File: rtl/core/smf_scan.sv
module smf_scan
  import smf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  stage_t      stage,
  output logic        take,
  smf_out_if.source   out_ch
);

  mode_t                 mode_r, mode_nxt, eff_mode, mode_mid;
  logic [DEPTH_BITS-1:0] depth_r, depth_nxt;
  logic [LEN_BITS-1:0]   hash_r, hash_nxt, eff_hash;
  logic [LEN_BITS+3:0]   hash_mul;
  logic                  out_valid_r;
  logic [7:0]            echo_r;
  logic                  keep_r, keep_nxt;
  status_t               status_r, status_nxt;
  logic [7:0]            c;
  logic                  is_blank, is_digit, blank_drop, bad_start, bad_hash;

  assign c = stage.data;

  // move when the result register is empty or being drained
  assign take = stage.vld && (!out_valid_r || out_ch.ready);

  // decode of the current byte against the effective mode
  always_comb begin
    eff_mode = (mode_r == MODE_DONE) ? MODE_START : mode_r;
    eff_hash = (mode_r == MODE_DONE) ? '0 : hash_r;
    is_blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL) || (c == CH_FF);
    is_digit = c inside {[CH_ZERO:CH_NINE]};
    blank_drop = (eff_mode == MODE_START) && (c != CH_LPAREN) && is_blank;
    bad_start  = ((eff_mode == MODE_START) || (eff_mode == MODE_ERROR)) &&
                 (c != CH_LPAREN) && !blank_drop;
    bad_hash   = (eff_mode == MODE_HASH) && !is_digit && (c != CH_DQUOTE);
  end

  // hash count times ten plus digit
  assign hash_mul = {1'b0, eff_hash, 3'b000} + {3'b000, eff_hash, 1'b0} +
                    {{(LEN_BITS){1'b0}}, c[3:0]};

  // next state
  always_comb begin
    mode_mid  = eff_mode;
    depth_nxt = depth_r;
    hash_nxt  = eff_hash;
    case (eff_mode)
      MODE_START, MODE_ERROR: begin
        if (c == CH_LPAREN) begin
          depth_nxt = {{(DEPTH_BITS-1){1'b0}}, 1'b1};
          mode_mid  = MODE_NORMAL;
        end else if (bad_start) begin
          mode_mid = MODE_ERROR;
        end
      end
      MODE_NORMAL: begin
        if (c == CH_LPAREN) begin
          if (depth_r != '1) depth_nxt = depth_r + 1'b1;
        end else if (c == CH_RPAREN) begin
          if (depth_r != '0) depth_nxt = depth_r - 1'b1;
        end else if (c == CH_DQUOTE) begin
          mode_mid = MODE_QUOTED;
        end else if (c == CH_HASH) begin
          mode_mid = MODE_HASH;
          hash_nxt = '0;
        end
      end
      MODE_QUOTED: begin
        if (c == CH_BSLASH) begin
          mode_mid = MODE_BSLASH;
        end else if (c == CH_DQUOTE) begin
          mode_mid = MODE_NORMAL;
        end
      end
      MODE_BSLASH: begin
        mode_mid = MODE_QUOTED;
      end
      MODE_HASH: begin
        if (is_digit) begin
          // saturate the byte count
          if (hash_mul[LEN_BITS+3:LEN_BITS] != '0) hash_nxt = '1;
          else hash_nxt = hash_mul[LEN_BITS-1:0];
        end else if (c == CH_DQUOTE) begin
          mode_mid = (eff_hash != '0) ? MODE_HASHED : MODE_NORMAL;
        end else begin
          mode_mid = MODE_NORMAL;
        end
      end
      default: begin
        // counted string body
        if (eff_hash != '0) hash_nxt = eff_hash - 1'b1;
        if (hash_nxt == '0) mode_mid = MODE_NORMAL;
      end
    endcase
    mode_nxt = mode_mid;
    if (!bad_start && !bad_hash && (mode_mid == MODE_NORMAL) && (depth_nxt == '0)) begin
      mode_nxt = MODE_DONE;
    end
  end

  // result fields
  always_comb begin
    keep_nxt = !(blank_drop || bad_start || bad_hash);
    if (bad_start) begin
      status_nxt = ST_BAD_START;
    end else if (bad_hash) begin
      status_nxt = ST_BAD_HASH;
    end else if (mode_nxt == MODE_DONE) begin
      status_nxt = ST_COMPLETE;
    end else begin
      status_nxt = ST_CONTINUE;
    end
  end

  // scanner state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_START;
      depth_r <= '0;
      hash_r  <= '0;
    end else if (take) begin
      mode_r  <= mode_nxt;
      depth_r <= depth_nxt;
      hash_r  <= hash_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      echo_r   <= c;
      keep_r   <= keep_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.echo_byte    = echo_r;
  assign out_ch.keep_byte    = keep_r;
  assign out_ch.frame_status = status_r;

endmodule

// File: rtl/core/sexpr_message_framer_core.sv
// channel  | dir | payload                                   | handshake
// in_ch    | in  | data_byte[7:0]                            | valid/ready
// out_ch   | out | echo_byte[7:0], keep_byte, frame_status[1:0] | valid/ready
//
// one byte per cycle sustained while out_ch is ready; each byte passes an input register, the
// scanner logic and a result register, from which the result is offered on out_ch
// rst_n is synchronous and active low; it returns the scanner to awaiting '('
// a stalled result holds while one more byte waits in the input register
module sexpr_message_framer_core
  import smf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  smf_in_if.sink    in_ch,
  smf_out_if.source out_ch
);

  stage_t stage;
  logic   take;

  // input register
  smf_in_reg u_in_reg (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .take  (take),
    .stage (stage)
  );

  // scanner and result register
  smf_scan u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .stage  (stage),
    .take   (take),
    .out_ch (out_ch)
  );

endmodule

// File: rtl/core/smf_checker.sv
module smf_checker
  import smf_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  smf_in_if.sink    in_ch,
  smf_out_if.source out_ch
);

  logic [1:0] inflight_r;
  logic       awaiting_r;
  logic       in_acc, out_acc;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;

  // requests accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else if (in_acc && !out_acc) begin
      inflight_r <= inflight_r + 1'b1;
    end else if (out_acc && !in_acc) begin
      inflight_r <= inflight_r - 1'b1;
    end
  end

  // between frames until a kept byte is seen
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_r <= 1'b1;
    end else if (out_acc) begin
      if (out_ch.frame_status == ST_COMPLETE) awaiting_r <= 1'b1;
      else if (out_ch.keep_byte) awaiting_r <= 1'b0;
    end
  end

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> inflight_r != 2'd0)
    else $error("result without accepted byte");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r != 2'd3)
    else $error("too many bytes in flight");

  a_frame_opens: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && awaiting_r && out_ch.keep_byte |-> out_ch.echo_byte == CH_LPAREN)
    else $error("frame kept without opening parenthesis");

  a_bad_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.frame_status == ST_BAD_START |->
      !out_ch.keep_byte && out_ch.echo_byte != CH_LPAREN)
    else $error("bad start on a kept or opening byte");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.echo_byte) &&
      $stable(out_ch.keep_byte) && $stable(out_ch.frame_status))
    else $error("stalled result changed");

endmodule

bind sexpr_message_framer_core smf_checker u_smf_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);
